// File: design/utl_pkg.sv
`timescale 1ns / 1ps

package utl_pkg;

    // Widths of the interface fields.
    localparam int CHAR_W    = 6;
    localparam int OFFSET_W  = 5;
    localparam int PAIR_W    = 7;   // two decimal digits, 0..99
    localparam int YEAR_W    = 7;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;

    localparam logic [OFFSET_W-1:0] TZ_OFFSET_RESET = OFFSET_W'(8);

    // ASCII digit bounds.
    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_NINE = CHAR_W'(57);

    // Calendar constants.
    localparam logic [PAIR_W-1:0] MONTH_JAN = PAIR_W'(1);
    localparam logic [PAIR_W-1:0] MONTH_FEB = PAIR_W'(2);
    localparam logic [PAIR_W-1:0] MONTH_MAR = PAIR_W'(3);
    localparam logic [PAIR_W-1:0] MONTH_APR = PAIR_W'(4);
    localparam logic [PAIR_W-1:0] MONTH_MAY = PAIR_W'(5);
    localparam logic [PAIR_W-1:0] MONTH_JUN = PAIR_W'(6);
    localparam logic [PAIR_W-1:0] MONTH_JUL = PAIR_W'(7);
    localparam logic [PAIR_W-1:0] MONTH_AUG = PAIR_W'(8);
    localparam logic [PAIR_W-1:0] MONTH_SEP = PAIR_W'(9);
    localparam logic [PAIR_W-1:0] MONTH_OCT = PAIR_W'(10);
    localparam logic [PAIR_W-1:0] MONTH_NOV = PAIR_W'(11);
    localparam logic [PAIR_W-1:0] MONTH_DEC = PAIR_W'(12);
    localparam logic [PAIR_W-1:0] YEAR_LAST = PAIR_W'(99);

    localparam logic [DAY_W-1:0] DAYS_LONG  = DAY_W'(31);
    localparam logic [DAY_W-1:0] DAYS_SHORT = DAY_W'(30);
    localparam logic [DAY_W-1:0] DAYS_FEB   = DAY_W'(28);
    localparam logic [DAY_W-1:0] DAYS_LEAP  = DAY_W'(29);
    localparam logic [DAY_W-1:0] DAYS_NONE  = DAY_W'(0);

    localparam int HOURS_PER_DAY = 24;
    localparam int HOUR_SUM_W    = 8;   // 99 + 31 fits in 8 bits

    // Binary timestamp after the digit decode.
    typedef struct packed {
        logic [PAIR_W-1:0] year;
        logic [PAIR_W-1:0] month;
        logic [PAIR_W-1:0] day;
        logic [PAIR_W-1:0] hour;
        logic [PAIR_W-1:0] minute;
        logic [PAIR_W-1:0] second;
    } ts_bin_t;

    // Local time result.
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic                day_advanced;
    } local_time_t;

endpackage

// File: design/utl_pair_decode.sv
`timescale 1ns / 1ps

// Turns two ASCII digits into a binary value 0..99. A character that is
// not a decimal digit counts as zero.
module utl_pair_decode (
    input  logic [utl_pkg::CHAR_W-1:0] tens_char,
    input  logic [utl_pkg::CHAR_W-1:0] ones_char,
    output logic [utl_pkg::PAIR_W-1:0] value
);
    import utl_pkg::*;

    logic [3:0]        tens_digit;
    logic [3:0]        ones_digit;
    logic [PAIR_W-1:0] tens_times_ten;

    always_comb
    begin
        if (tens_char >= CHAR_ZERO && tens_char <= CHAR_NINE)
        begin
            tens_digit = 4'(tens_char - CHAR_ZERO);
        end
        else
        begin
            tens_digit = 4'd0;
        end
        if (ones_char >= CHAR_ZERO && ones_char <= CHAR_NINE)
        begin
            ones_digit = 4'(ones_char - CHAR_ZERO);
        end
        else
        begin
            ones_digit = 4'd0;
        end
    end

    // Ten times the tens digit as 8x + 2x.
    assign tens_times_ten = {tens_digit, 3'b000} + {2'b00, tens_digit, 1'b0};
    assign value          = tens_times_ten + {3'b000, ones_digit};

endmodule

// File: design/utl_calendar.sv
`timescale 1ns / 1ps

// Adds the hour offset and carries a wrapped hour into the day, month and
// year with the Gregorian month lengths.
module utl_calendar (
    input  utl_pkg::ts_bin_t                utc,
    input  logic [utl_pkg::OFFSET_W-1:0]    tz_offset,
    output utl_pkg::local_time_t            local_time
);
    import utl_pkg::*;

    logic [HOUR_SUM_W-1:0] hour_sum;
    logic [HOUR_SUM_W-1:0] hour_m96;
    logic [HOUR_SUM_W-1:0] hour_m48;
    logic [HOUR_SUM_W-1:0] hour_mod;
    logic                  carry;
    logic [PAIR_W-1:0]     day_inc;
    logic [DAY_W-1:0]      limit;
    logic                  leap;
    logic                  rollover;
    logic [PAIR_W-1:0]     day_out;
    logic [PAIR_W-1:0]     month_out;
    logic [PAIR_W-1:0]     year_out;

    assign hour_sum = {1'b0, utc.hour} + {3'b000, tz_offset};
    assign carry    = hour_sum >= HOUR_SUM_W'(HOURS_PER_DAY);

    // The sum is at most 99 + 31 = 130, below 6 * 24, so three conditional
    // subtractions of 96, 48 and 24 reduce it modulo 24.
    assign hour_m96 = (hour_sum >= HOUR_SUM_W'(4 * HOURS_PER_DAY))
                    ? hour_sum - HOUR_SUM_W'(4 * HOURS_PER_DAY) : hour_sum;
    assign hour_m48 = (hour_m96 >= HOUR_SUM_W'(2 * HOURS_PER_DAY))
                    ? hour_m96 - HOUR_SUM_W'(2 * HOURS_PER_DAY) : hour_m96;
    assign hour_mod = (hour_m48 >= HOUR_SUM_W'(HOURS_PER_DAY))
                    ? hour_m48 - HOUR_SUM_W'(HOURS_PER_DAY) : hour_m48;

    // Years 2000 to 2099: divisible by four is the whole leap rule here,
    // since 2000 is a leap year and 2100 is out of range.
    assign leap    = (utc.year[1:0] == 2'b00);
    assign day_inc = utc.day + PAIR_W'(1);

    always_comb
    begin
        unique case (utc.month)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC:
                limit = DAYS_LONG;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV:
                limit = DAYS_SHORT;
            MONTH_FEB:
                limit = leap ? DAYS_LEAP : DAYS_FEB;
            default:
                limit = DAYS_NONE;
        endcase
    end

    // A month outside the calendar never rolls over.
    assign rollover = carry && (limit != DAYS_NONE) && (day_inc > {2'b00, limit});

    always_comb
    begin
        day_out   = utc.day;
        month_out = utc.month;
        year_out  = utc.year;
        if (carry)
        begin
            day_out = day_inc;
        end
        if (rollover)
        begin
            day_out = PAIR_W'(1);
            if (utc.month == MONTH_DEC)
            begin
                month_out = MONTH_JAN;
                year_out  = (utc.year >= YEAR_LAST) ? PAIR_W'(0) : utc.year + PAIR_W'(1);
            end
            else
            begin
                month_out = utc.month + PAIR_W'(1);
            end
        end
    end

    always_comb
    begin
        local_time.year  = year_out;
        local_time.month = (month_out > PAIR_W'(15)) ? MONTH_W'(15) : month_out[MONTH_W-1:0];
        local_time.day   = (day_out > PAIR_W'(31)) ? DAY_W'(31) : day_out[DAY_W-1:0];
        local_time.hour  = hour_mod[HOUR_W-1:0];
        local_time.minute       = utc.minute[MINUTE_W-1:0];
        local_time.second       = utc.second[SECOND_W-1:0];
        local_time.day_advanced = carry;
    end

endmodule

// File: design/utc_to_local_time_offset.sv
`timescale 1ns / 1ps

// UTC to local time converter. A transaction on the ts channel carries a
// UTC timestamp as twelve ASCII digits (year 2000-2099, month, day, hour,
// minute, second); the block adds tz_offset_hours (reset value 8) to the
// hour, wraps it modulo 24 and, when it wraps, advances the day, month and
// year by the calendar with Gregorian leap years. Each input transaction
// yields exactly one result transaction on the res channel, and the
// block takes a new timestamp every cycle while res_ready is held high:
// the digits are decoded into a binary input register and the calendar
// logic fills a result register, each stage advancing when it has room
// under the usual valid/ready flow. The offset is written through
// cfg_write/tz_offset_hours and should only change while no transaction
// is in flight. Characters that are not digits count as zero, a day above
// 31 or month above 15 saturates, and year 99 wraps to 0.
module utc_to_local_time_offset (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [utl_pkg::OFFSET_W-1:0]  tz_offset_hours,

    input  logic                          ts_valid,
    output logic                          ts_ready,
    input  logic [utl_pkg::CHAR_W-1:0]    year_tens_char,
    input  logic [utl_pkg::CHAR_W-1:0]    year_ones_char,
    input  logic [utl_pkg::CHAR_W-1:0]    month_tens_char,
    input  logic [utl_pkg::CHAR_W-1:0]    month_ones_char,
    input  logic [utl_pkg::CHAR_W-1:0]    day_tens_char,
    input  logic [utl_pkg::CHAR_W-1:0]    day_ones_char,
    input  logic [utl_pkg::CHAR_W-1:0]    hour_tens_char,
    input  logic [utl_pkg::CHAR_W-1:0]    hour_ones_char,
    input  logic [utl_pkg::CHAR_W-1:0]    minute_tens_char,
    input  logic [utl_pkg::CHAR_W-1:0]    minute_ones_char,
    input  logic [utl_pkg::CHAR_W-1:0]    second_tens_char,
    input  logic [utl_pkg::CHAR_W-1:0]    second_ones_char,

    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [utl_pkg::YEAR_W-1:0]    local_year,
    output logic [utl_pkg::MONTH_W-1:0]   local_month,
    output logic [utl_pkg::DAY_W-1:0]     local_day,
    output logic [utl_pkg::HOUR_W-1:0]    local_hour,
    output logic [utl_pkg::MINUTE_W-1:0]  local_minute,
    output logic [utl_pkg::SECOND_W-1:0]  local_second,
    output logic                          day_advanced
);
    import utl_pkg::*;

    // Offset register.
    logic [OFFSET_W-1:0] offset_reg;

    // Input stage: decoded timestamp.
    ts_bin_t     ts_next;
    ts_bin_t     ts_reg;
    logic        ts_valid_reg;

    // Result stage.
    local_time_t res_next;
    local_time_t res_reg;
    logic        res_valid_reg;

    logic        res_load;
    logic        ts_load;

    // The result register can take a new value when it is empty or being
    // drained this cycle; the input register likewise when its contents
    // move on to the result register.
    assign res_load = !res_valid_reg || res_ready;
    assign ts_ready = !ts_valid_reg || res_load;
    assign ts_load  = ts_valid && ts_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= TZ_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            offset_reg <= tz_offset_hours;
        end
    end

    // Digit decode ahead of the input register, one pair per field.
    utl_pair_decode u_year (
        .tens_char (year_tens_char),
        .ones_char (year_ones_char),
        .value     (ts_next.year)
    );

    utl_pair_decode u_month (
        .tens_char (month_tens_char),
        .ones_char (month_ones_char),
        .value     (ts_next.month)
    );

    utl_pair_decode u_day (
        .tens_char (day_tens_char),
        .ones_char (day_ones_char),
        .value     (ts_next.day)
    );

    utl_pair_decode u_hour (
        .tens_char (hour_tens_char),
        .ones_char (hour_ones_char),
        .value     (ts_next.hour)
    );

    utl_pair_decode u_minute (
        .tens_char (minute_tens_char),
        .ones_char (minute_ones_char),
        .value     (ts_next.minute)
    );

    utl_pair_decode u_second (
        .tens_char (second_tens_char),
        .ones_char (second_ones_char),
        .value     (ts_next.second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_valid_reg <= 1'b0;
        end
        else if (ts_ready)
        begin
            ts_valid_reg <= ts_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ts_load)
        begin
            ts_reg <= ts_next;
        end
    end

    // Offset addition and calendar carry between the two registers.
    utl_calendar u_calendar (
        .utc        (ts_reg),
        .tz_offset  (offset_reg),
        .local_time (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= ts_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load && ts_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign local_year   = res_reg.year;
    assign local_month  = res_reg.month;
    assign local_day    = res_reg.day;
    assign local_hour   = res_reg.hour;
    assign local_minute = res_reg.minute;
    assign local_second = res_reg.second;
    assign day_advanced = res_reg.day_advanced;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the UTC to local time converter. Timestamps go in
// as twelve ASCII characters on the ts channel. An in-bench calendar model
// predicts the local time for every accepted transaction, and the result
// from the res channel is compared field by field against the oldest
// prediction still outstanding.
module tb;

    import utl_pkg::*;

    // Twelve characters of one timestamp. Element 0 is the tens digit of the
    // year and element 11 is the ones digit of the second.
    typedef logic [11:0][CHAR_W-1:0] stamp_t;

    localparam int RESET_CYCLES     = 7;
    localparam int DRAIN_CYCLES     = 6;      // pipeline is two stages deep
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int MONTH_SAT        = 15;     // local_month saturates here
    localparam int DAY_SAT          = DAYS_LONG;
    localparam int LAST_HOUR        = HOURS_PER_DAY - 1;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [OFFSET_W-1:0]  tz_offset_hours;
    logic                 ts_valid;
    logic                 ts_ready;
    stamp_t               ts_chars;
    logic                 res_valid;
    logic                 res_ready;
    logic [YEAR_W-1:0]    local_year;
    logic [MONTH_W-1:0]   local_month;
    logic [DAY_W-1:0]     local_day;
    logic [HOUR_W-1:0]    local_hour;
    logic [MINUTE_W-1:0]  local_minute;
    logic [SECOND_W-1:0]  local_second;
    logic                 day_advanced;

    // Offset the bench believes is loaded in the block.
    logic [OFFSET_W-1:0]  offset_hours;

    // Local times predicted for accepted timestamps, oldest first.
    local_time_t          pending_local_q [$];

    int unsigned          mismatch_count;

    // Traffic knobs: percent odds that a random idle burst starts, per accepted
    // stamp (sender) or per cycle (receiver). In the quiet tail neither side idles.
    int unsigned          src_gap_pct;
    int unsigned          sink_stall_pct;
    bit                   quiet_tail;
    bit                   long_hold_req;

    always #6 clk = ~clk;

    utc_to_local_time_offset DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .tz_offset_hours  (tz_offset_hours),
        .ts_valid         (ts_valid),
        .ts_ready         (ts_ready),
        .year_tens_char   (ts_chars[0]),
        .year_ones_char   (ts_chars[1]),
        .month_tens_char  (ts_chars[2]),
        .month_ones_char  (ts_chars[3]),
        .day_tens_char    (ts_chars[4]),
        .day_ones_char    (ts_chars[5]),
        .hour_tens_char   (ts_chars[6]),
        .hour_ones_char   (ts_chars[7]),
        .minute_tens_char (ts_chars[8]),
        .minute_ones_char (ts_chars[9]),
        .second_tens_char (ts_chars[10]),
        .second_ones_char (ts_chars[11]),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .local_year       (local_year),
        .local_month      (local_month),
        .local_day        (local_day),
        .local_hour       (local_hour),
        .local_minute     (local_minute),
        .local_second     (local_second),
        .day_advanced     (day_advanced)
    );

    // ------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------

    // Any character outside '0'..'9' decodes as zero.
    function automatic int unsigned digit_value(logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO && c <= CHAR_NINE) ? int'(c - CHAR_ZERO) : 0;
    endfunction

    function automatic int unsigned pair_value(logic [CHAR_W-1:0] tens,
                                               logic [CHAR_W-1:0] ones);
        return digit_value(tens) * 10 + digit_value(ones);
    endfunction

    // Days in a month of year 2000+yy. A month outside 1..12 has no length,
    // which means it never rolls over.
    function automatic int unsigned month_length(int unsigned yy, int unsigned mm);
        int unsigned full_year;
        bit          leap;
        full_year = 2000 + yy;
        leap = ((full_year % 4 == 0) && (full_year % 100 != 0)) || (full_year % 400 == 0);
        case (mm)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC:            return DAYS_LONG;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return DAYS_SHORT;
            MONTH_FEB:                                  return leap ? DAYS_LEAP : DAYS_FEB;
            default:                                    return DAYS_NONE;
        endcase
    endfunction

    // Shifts one UTC timestamp by the offset. The day advances at most once,
    // even for offsets above 23, and only the hour carry moves the calendar.
    function automatic local_time_t shift_to_local(stamp_t s, logic [OFFSET_W-1:0] offs);
        local_time_t r;
        int unsigned yy, mm, dd, hh, len;
        yy = pair_value(s[0], s[1]);
        mm = pair_value(s[2], s[3]);
        dd = pair_value(s[4], s[5]);
        hh = pair_value(s[6], s[7]) + offs;
        r.day_advanced = 1'b0;
        if (hh > LAST_HOUR)
        begin
            hh = hh % HOURS_PER_DAY;
            r.day_advanced = 1'b1;
            dd++;
            len = month_length(yy, mm);
            if (len != 0 && dd > len)
            begin
                dd = 1;
                if (mm == MONTH_DEC)
                begin
                    mm = MONTH_JAN;
                    yy = (yy >= YEAR_LAST) ? 0 : yy + 1;
                end
                else
                begin
                    mm++;
                end
            end
        end
        if (mm > MONTH_SAT) mm = MONTH_SAT;
        if (dd > DAY_SAT) dd = DAY_SAT;
        r.year   = YEAR_W'(yy);
        r.month  = MONTH_W'(mm);
        r.day    = DAY_W'(dd);
        r.hour   = HOUR_W'(hh);
        r.minute = MINUTE_W'(pair_value(s[8], s[9]));
        r.second = SECOND_W'(pair_value(s[10], s[11]));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stamp_t encode_stamp(input int unsigned yy, mm, dd, hh, mi, ss);
        int unsigned vals [6];
        stamp_t      s;
        vals = '{yy, mm, dd, hh, mi, ss};
        for (int i = 0; i < 6; i++)
        begin
            s[2*i]   = CHAR_ZERO + CHAR_W'(vals[i] / 10);
            s[2*i+1] = CHAR_ZERO + CHAR_W'(vals[i] % 10);
        end
        return s;
    endfunction

    // Mostly valid dates with a bias toward late hours and month ends, so
    // that the carry and rollover paths get plenty of traffic. The rest is
    // raw characters, digits or not, which also toggles every input bit.
    function automatic stamp_t random_stamp();
        stamp_t      s;
        int unsigned yy, mm, dd, hh, len;
        if ($urandom_range(0, 99) < 12)
        begin
            for (int i = 0; i < 12; i++)
                s[i] = $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, 63))
                                            : CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
            return s;
        end
        yy  = ($urandom_range(0, 9) == 0) ? YEAR_LAST : $urandom_range(0, 99);
        mm  = $urandom_range(1, 12);
        len = month_length(yy, mm);
        dd  = ($urandom_range(0, 2) == 0) ? len : $urandom_range(1, len);
        hh  = $urandom_range(0, 1) ? $urandom_range(16, LAST_HOUR) : $urandom_range(0, LAST_HOUR);
        return encode_stamp(yy, mm, dd, hh, $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    // Offers one timestamp; returns at the edge where it is accepted, or after
    // the random gap that may follow. Must be entered at a rising edge. Valid
    // stays high into the next call unless a random gap follows.
    task automatic send_stamp(stamp_t s);
        ts_valid <= 1'b1;
        ts_chars <= s;
        do @(posedge clk); while (!ts_ready);
        if (!quiet_tail && $urandom_range(0, 99) < src_gap_pct)
        begin
            ts_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Stops offering, waits for every outstanding result, then lets the
    // pipeline settle.
    task automatic wait_drained();
        ts_valid <= 1'b0;
        do @(posedge clk); while (pending_local_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The offset is only changed with nothing in flight.
    task automatic write_offset(logic [OFFSET_W-1:0] value);
        wait_drained();
        cfg_write       <= 1'b1;
        tz_offset_hours <= value;
        @(posedge clk);
        cfg_write    <= 1'b0;
        offset_hours  = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Calendar corners at the reset offset of 8 hours, with no write first.
    task automatic test_default_offset();
        stamp_t cases [$];
        cases = '{
            encode_stamp( 0,  1,  1,  0,  0,  0),   // no carry at all
            encode_stamp(23, 12, 31, 16,  0,  0),   // new year
            encode_stamp(99, 12, 31, 23, 59, 59),   // year 99 wraps to 0
            encode_stamp(24,  2, 28, 20, 30,  0),   // leap February
            encode_stamp(23,  2, 28, 20,  0,  0),   // common February
            encode_stamp( 0,  2, 29, 18,  0,  0),   // 2000 is leap by the 400 rule
            encode_stamp(24,  4, 30, 18, 12, 34),   // 30-day month
            encode_stamp(24, 11, 30, 15, 45,  6),   // lands on 23, no carry
            encode_stamp(24,  6, 15, 16,  1,  2)    // lands on 0, carries
        };
        foreach (cases[i]) send_stamp(cases[i]);
        wait_drained();
    endtask

    // Malformed input and offset extremes.
    task automatic test_calendar_corners();
        stamp_t cases [$];
        stamp_t colon_hour;
        colon_hour    = encode_stamp(24, 5, 10, 20, 0, 0);
        colon_hour[6] = CHAR_NINE + 1'b1;           // ':' counts as a zero digit
        cases = '{
            '1,                                     // every character 63
            '0,                                     // every character 0
            colon_hour,
            encode_stamp(24,  0,  5, 20,  0,  0),   // month 0 with carry
            encode_stamp(24, 13, 31, 20,  0,  0),   // month 13, day saturates
            encode_stamp(24, 99, 99, 99, 99, 99),   // every pair at 99
            encode_stamp(24,  1, 35, 20,  0,  0),   // day beyond month length
            encode_stamp(24,  2,  0, 20,  0,  0)    // day 0 with carry
        };
        foreach (cases[i]) send_stamp(cases[i]);

        // An offset above 23 still advances the day only once.
        write_offset(OFFSET_W'(31));
        send_stamp(encode_stamp(24, 3, 10, 23, 0, 0));
        send_stamp(encode_stamp(24, 3, 10,  0, 0, 0));
        write_offset(OFFSET_W'(0));
        send_stamp(encode_stamp(24, 12, 31, 23, 59, 59));
        write_offset(OFFSET_W'(23));
        send_stamp(encode_stamp(24, 12, 31,  1,  0,  0));
        wait_drained();
    endtask

    // Random phases, each with its own offset and idle rates. The first
    // phases pin the offset extremes; zero rates give stretches with no
    // idling on that side.
    task automatic test_random_traffic();
        int unsigned rates [3];
        logic [OFFSET_W-1:0] offs;
        rates = '{0, 10, 30};
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       offs = OFFSET_W'(0);
                1:       offs = OFFSET_W'(LAST_HOUR);
                2:       offs = '1;
                default: offs = OFFSET_W'($urandom_range(0, 31));
            endcase
            write_offset(offs);
            src_gap_pct    = rates[$urandom_range(0, 2)];
            sink_stall_pct = rates[$urandom_range(0, 2)];
            for (int i = 0; i < 70; i++) send_stamp(random_stamp());
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the pipeline fills and ts_ready must drop. Afterwards
    // the sender pauses until every result is back; ten more follow with random idling.
    task automatic test_output_backpressure();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        long_hold_req  = 1'b1;
        for (int i = 0; i < 30; i++) send_stamp(random_stamp());
        wait_drained();
        src_gap_pct    = 30;
        sink_stall_pct = 30;
        for (int i = 0; i < 10; i++) send_stamp(random_stamp());
        wait_drained();
    endtask

    // Back-to-back transactions with both sides always ready.
    task automatic test_streaming_tail();
        quiet_tail = 1'b1;
        write_offset(OFFSET_W'($urandom_range(0, 31)));
        for (int i = 0; i < 60; i++) send_stamp(random_stamp());
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus the long hold on request. The hold
    // is counted here so that the sender keeps running meanwhile.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                res_ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < sink_stall_pct)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                res_ready <= 1'b1;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard. Results are checked before the new prediction is queued;
    // the input and result registers keep a transaction's result behind its
    // acceptance, so the order is safe.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        local_time_t want;
        if (rst_n === 1'b1)
        begin
            if (res_valid && res_ready)
            begin
                if (pending_local_q.size() == 0)
                begin
                    $error("result transaction with no timestamp outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_local_q.pop_front();
                    check_field("local_year",   want.year,         local_year);
                    check_field("local_month",  want.month,        local_month);
                    check_field("local_day",    want.day,          local_day);
                    check_field("local_hour",   want.hour,         local_hour);
                    check_field("local_minute", want.minute,       local_minute);
                    check_field("local_second", want.second,       local_second);
                    check_field("day_advanced", want.day_advanced, day_advanced);
                end
            end
            if (ts_valid && ts_ready)
                pending_local_q.push_back(shift_to_local(ts_chars, offset_hours));
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        tz_offset_hours = TZ_OFFSET_RESET;
        ts_valid        = 1'b0;
        ts_chars        = '0;
        offset_hours    = TZ_OFFSET_RESET;
        mismatch_count  = 0;
        src_gap_pct     = 20;
        sink_stall_pct  = 10;
        quiet_tail      = 1'b0;
        long_hold_req   = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_offset();
        test_calendar_corners();
        test_random_traffic();
        test_output_backpressure();
        test_streaming_tail();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
